// ===== sv/tlc_pkg.sv =====
// Shared types and constants for the tile LRU cache.
package tlc_pkg;

   localparam int COORD_W = 13;
   localparam int TILE_W  = 9;
   localparam int PIX_W   = 16;
   localparam int CAP_W   = 7;
   localparam int SLOT_W  = 6;
   localparam int AREA_W  = 18;
   localparam int SUM_W   = 64;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [2:0] REG_TILE_WIDTH    = 3'd0;
   localparam logic [2:0] REG_TILE_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_RASTER_WIDTH  = 3'd2;
   localparam logic [2:0] REG_RASTER_HEIGHT = 3'd3;
   localparam logic [2:0] REG_TILE_CAPACITY = 3'd4;

   typedef struct packed {
      logic [TILE_W-1:0] tile_px_w;
      logic [TILE_W-1:0] tile_px_h;
      logic [PIX_W-1:0]  raster_width;
      logic [PIX_W-1:0]  raster_height;
      logic [CAP_W-1:0]  tile_capacity;
   } cfg_type;

   // classified request as handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] tile_col;
      logic [COORD_W-1:0] tile_row;
      logic               bad_tile;
      logic [PIX_W-1:0]   start_x;
      logic [PIX_W-1:0]   start_y;
      logic [TILE_W-1:0]  count_x;
      logic [TILE_W-1:0]  count_y;
   } mid_item_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               bad_tile;
      logic [PIX_W-1:0]   fetch_start_x;
      logic [PIX_W-1:0]   fetch_start_y;
      logic [TILE_W-1:0]  fetch_count_x;
      logic [TILE_W-1:0]  fetch_count_y;
      logic [SUM_W-1:0]   loaded_total;
   } rsp_item_type;

endpackage

// ===== sv/tlc_fifo.sv =====
// Small register queue used between the front, the back and the result port.
module tlc_fifo #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type push_data,
   output logic     full,
   input  logic     pop,
   output data_type pop_data,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   data_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/tlc_front.sv =====
// Front end: takes requests, works out pixel origin, raster check and clipped window.
module tlc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  tlc_pkg::cfg_type              cfg,
   input  logic                          push,
   output logic                          full,
   input  logic [tlc_pkg::COORD_W-1:0]   tile_col,
   input  logic [tlc_pkg::COORD_W-1:0]   tile_row,
   output logic                          mid_push,
   output tlc_pkg::mid_item_type         mid_data,
   input  logic                          mid_full
);

   localparam int PW = tlc_pkg::COORD_W + tlc_pkg::TILE_W;

   logic                        a_vld_ff, a_vld_in;
   logic [tlc_pkg::COORD_W-1:0] a_col_ff, a_row_ff;
   logic                        b_vld_ff, b_vld_in;
   logic [tlc_pkg::COORD_W-1:0] b_col_ff, b_row_ff;
   logic [PW-1:0]               b_sx_ff, b_sy_ff;
   logic                        a_take, b_take, accept;
   logic [tlc_pkg::PIX_W-1:0]   rem_x, rem_y;

   assign b_take   = !b_vld_ff || !mid_full;
   assign a_take   = !a_vld_ff || b_take;
   assign full     = !a_take;
   assign accept   = push && a_take;
   assign a_vld_in = a_take ? accept : a_vld_ff;
   assign b_vld_in = b_take ? a_vld_ff : b_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_col_ff <= tile_col;
         a_row_ff <= tile_row;
      end
      if (b_take && a_vld_ff) begin
         b_col_ff <= a_col_ff;
         b_row_ff <= a_row_ff;
         b_sx_ff  <= PW'(a_col_ff) * PW'(cfg.tile_px_w);
         b_sy_ff  <= PW'(a_row_ff) * PW'(cfg.tile_px_h);
      end
   end

   // window end clips at the raster edge: count = min(tile size, raster - start)
   assign rem_x = cfg.raster_width  - b_sx_ff[tlc_pkg::PIX_W-1:0];
   assign rem_y = cfg.raster_height - b_sy_ff[tlc_pkg::PIX_W-1:0];

   always_comb begin
      mid_data.tile_col = b_col_ff;
      mid_data.tile_row = b_row_ff;
      mid_data.bad_tile = (b_sx_ff >= PW'(cfg.raster_width)) ||
                          (b_sy_ff >= PW'(cfg.raster_height));
      mid_data.start_x  = b_sx_ff[tlc_pkg::PIX_W-1:0];
      mid_data.start_y  = b_sy_ff[tlc_pkg::PIX_W-1:0];
      mid_data.count_x  = (rem_x < tlc_pkg::PIX_W'(cfg.tile_px_w)) ?
                          rem_x[tlc_pkg::TILE_W-1:0] : cfg.tile_px_w;
      mid_data.count_y  = (rem_y < tlc_pkg::PIX_W'(cfg.tile_px_h)) ?
                          rem_y[tlc_pkg::TILE_W-1:0] : cfg.tile_px_h;
   end

   assign mid_push = b_vld_ff && !mid_full;

endmodule

// ===== sv/tlc_back.sv =====
// Back end: tag match over all slots, LRU rank update, fill and loaded-sample total.
module tlc_back #(
   parameter int SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlc_pkg::cfg_type              cfg,
   input  logic                          cfg_clear,
   input  logic                          mid_empty,
   input  tlc_pkg::mid_item_type         mid_data,
   output logic                          mid_pop,
   input  logic                          out_full,
   output logic                          out_push,
   output tlc_pkg::rsp_item_type         out_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FW = $clog2(SLOTS + 1);
   localparam int CW = (FW > tlc_pkg::CAP_W) ? FW : tlc_pkg::CAP_W;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_MATCH   = 2'd1;
   localparam logic [1:0] S_RESOLVE = 2'd2;
   localparam logic [1:0] S_DONE    = 2'd3;

   logic [1:0]                  state_ff, state_in;
   tlc_pkg::mid_item_type       item_ff;
   logic [FW-1:0]               filled_ff, filled_in;
   logic [tlc_pkg::SUM_W-1:0]   sum_ff, sum_in;

   logic [tlc_pkg::COORD_W-1:0] tag_col_ff [SLOTS];
   logic [tlc_pkg::COORD_W-1:0] tag_row_ff [SLOTS];
   logic [IW-1:0]               age_ff     [SLOTS];
   logic [IW-1:0]               age_in     [SLOTS];

   logic [SLOTS-1:0]            vld;
   logic [SLOTS-1:0]            match_ff, match_in;
   logic [SLOTS-1:0]            lru_ff, lru_in;
   logic [tlc_pkg::AREA_W-1:0]  area_ff;
   logic                        hit_ff;
   logic                        fresh_ff;
   logic [IW-1:0]               target_ff, target_in;
   logic [IW-1:0]               limit_ff, limit_in;
   logic                        fresh;
   logic [IW-1:0]               hit_idx, lru_idx, hit_age;
   logic                        do_update, do_fill;

   function automatic logic [IW-1:0] encode(input logic [SLOTS-1:0] vec);
      logic [IW-1:0] idx;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (vec[i]) begin
            idx = idx | IW'(i);
         end
      end
      return idx;
   endfunction

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         vld[i] = (FW'(i) < filled_ff);
      end
   end

   // tag compare and LRU candidate, one comparator pair per slot
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = vld[i] && (tag_col_ff[i] == item_ff.tile_col) &&
                       (tag_row_ff[i] == item_ff.tile_row);
         lru_in[i]   = vld[i] && (age_ff[i] == IW'(filled_ff - FW'(1)));
      end
   end

   always_comb begin
      hit_age = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match_ff[i]) begin
            hit_age = hit_age | age_ff[i];
         end
      end
   end

   assign hit_idx = encode(match_ff);
   assign lru_idx = encode(lru_ff);
   assign fresh   = CW'(filled_ff) < CW'(cfg.tile_capacity);

   // ranks below limit move back by one; a new tile on a fresh slot ages every filled one
   always_comb begin
      if (|match_ff) begin
         target_in = hit_idx;
         limit_in  = hit_age;
      end else if (fresh) begin
         target_in = IW'(filled_ff);
         limit_in  = IW'(filled_ff);
      end else begin
         target_in = lru_idx;
         limit_in  = IW'(filled_ff - FW'(1));
      end
   end

   assign mid_pop   = (state_ff == S_IDLE) && !mid_empty;
   assign out_push  = (state_ff == S_DONE) && !out_full;
   assign do_update = out_push && !item_ff.bad_tile;
   assign do_fill   = do_update && !hit_ff;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         age_in[i] = age_ff[i];
         if (vld[i] && (age_ff[i] < limit_ff)) begin
            age_in[i] = age_ff[i] + IW'(1);
         end
         if (IW'(i) == target_ff) begin
            age_in[i] = '0;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!mid_empty) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (do_fill) begin
         sum_in = sum_ff + tlc_pkg::SUM_W'(area_ff);
         if (fresh_ff) begin
            filled_in = filled_ff + FW'(1);
         end
      end
      if (cfg_clear) begin
         filled_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         filled_ff <= '0;
         sum_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         filled_ff <= filled_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         item_ff <= mid_data;
      end
      if (state_ff == S_MATCH) begin
         match_ff <= match_in;
         lru_ff   <= lru_in;
         area_ff  <= tlc_pkg::AREA_W'(item_ff.count_x) * tlc_pkg::AREA_W'(item_ff.count_y);
      end
      if (state_ff == S_RESOLVE) begin
         hit_ff    <= |match_ff;
         fresh_ff  <= fresh;
         target_ff <= target_in;
         limit_ff  <= limit_in;
      end
      if (do_update) begin
         for (int i = 0; i < SLOTS; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
      if (do_fill) begin
         tag_col_ff[target_ff] <= item_ff.tile_col;
         tag_row_ff[target_ff] <= item_ff.tile_row;
      end
   end

   always_comb begin
      out_data               = '0;
      out_data.loaded_total  = sum_ff;
      if (item_ff.bad_tile) begin
         out_data.bad_tile = 1'b1;
      end else begin
         out_data.hit  = hit_ff;
         out_data.slot = 6'(target_ff);
         if (!hit_ff) begin
            out_data.fetch_start_x = item_ff.start_x;
            out_data.fetch_start_y = item_ff.start_y;
            out_data.fetch_count_x = item_ff.count_x;
            out_data.fetch_count_y = item_ff.count_y;
            out_data.loaded_total  = sum_ff + tlc_pkg::SUM_W'(area_ff);
         end
      end
   end

   // filled tiles are unique, so at most one tag can match
   a_match_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE) |-> $onehot0(match_ff))
      else $error("more than one slot matched the request");

   a_lru_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE) |-> $onehot0(lru_ff))
      else $error("LRU rank held by more than one slot");

   a_lru_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE && match_ff == '0 && !fresh) |-> (lru_ff != '0))
      else $error("full cache without an LRU slot");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CW'(filled_ff) <= CW'(SLOTS))
      else $error("fill count beyond slot count");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      mid_pop |=> (state_ff == S_MATCH))
      else $error("queue beat taken without starting a lookup");

endmodule

// ===== sv/tile_lru_cache.sv =====
// Path: 2 front stages, the mid queue, the back-end lookup states, then the result queue.
// The back end works on one request at a time, through its match/resolve/update loop.
// The front takes a beat per cycle unless the mid queue is full; two small queues absorb bursts and result stalls.
// Reset: synchronous; cache empty, loaded total zero, registers at 32, 32, 1, 1, min(64, SLOTS).
// A write to any defined register empties the cache; the loaded total is kept.
module tile_lru_cache #(
   parameter int SLOTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [tlc_pkg::COORD_W-1:0]   req_tile_col,
   input  logic [tlc_pkg::COORD_W-1:0]   req_tile_row,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_hit,
   output logic [tlc_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_bad_tile,
   output logic [tlc_pkg::PIX_W-1:0]     rsp_fetch_start_x,
   output logic [tlc_pkg::PIX_W-1:0]     rsp_fetch_start_y,
   output logic [tlc_pkg::TILE_W-1:0]    rsp_fetch_count_x,
   output logic [tlc_pkg::TILE_W-1:0]    rsp_fetch_count_y,
   output logic [tlc_pkg::SUM_W-1:0]     rsp_loaded_total,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tlc_pkg::CSR_AW-1:0]    paddr,
   input  logic [tlc_pkg::CSR_DW-1:0]    pwdata,
   output logic [tlc_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int CAP_RST = (SLOTS < 64) ? SLOTS : 64;
   localparam int CW      = ($clog2(SLOTS + 1) > tlc_pkg::CAP_W) ?
                            $clog2(SLOTS + 1) : tlc_pkg::CAP_W;

   tlc_pkg::cfg_type       cfg_ff, cfg_in;
   logic                   wr_beat, cfg_clear;
   logic [2:0]             reg_idx;
   logic [8:0]             wd_tile_w, wd_tile_h;
   logic [15:0]            wd_ras_w, wd_ras_h;
   logic [6:0]             wd_cap;

   logic                   mid_push, mid_full, mid_pop, mid_empty;
   tlc_pkg::mid_item_type  mid_wdata, mid_rdata;
   logic                   out_push, out_full;
   tlc_pkg::rsp_item_type  out_wdata, out_rdata;

   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:2];

   assign wd_tile_w = pwdata[8:0];
   assign wd_tile_h = pwdata[8:0];
   assign wd_ras_w  = pwdata[15:0];
   assign wd_ras_h  = pwdata[15:0];
   assign wd_cap    = pwdata[6:0];

   // out-of-range field values saturate into the legal range; pwdata bits above each field are ignored
   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (wr_beat) begin
         unique case (reg_idx)
            tlc_pkg::REG_TILE_WIDTH: begin
               cfg_in.tile_px_w = (wd_tile_w < 9'd8) ? 9'd8 :
                                  (wd_tile_w > 9'd256) ? 9'd256 : wd_tile_w;
               cfg_clear = 1'b1;
            end
            tlc_pkg::REG_TILE_HEIGHT: begin
               cfg_in.tile_px_h = (wd_tile_h < 9'd8) ? 9'd8 :
                                  (wd_tile_h > 9'd256) ? 9'd256 : wd_tile_h;
               cfg_clear = 1'b1;
            end
            tlc_pkg::REG_RASTER_WIDTH: begin
               cfg_in.raster_width = (wd_ras_w == '0) ? 16'd1 : wd_ras_w;
               cfg_clear = 1'b1;
            end
            tlc_pkg::REG_RASTER_HEIGHT: begin
               cfg_in.raster_height = (wd_ras_h == '0) ? 16'd1 : wd_ras_h;
               cfg_clear = 1'b1;
            end
            tlc_pkg::REG_TILE_CAPACITY: begin
               cfg_in.tile_capacity = (wd_cap < 7'd2) ? 7'd2 :
                                      (CW'(wd_cap) > CW'(SLOTS)) ? 7'(SLOTS) : wd_cap;
               cfg_clear = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_px_w     <= 9'd32;
         cfg_ff.tile_px_h     <= 9'd32;
         cfg_ff.raster_width  <= 16'd1;
         cfg_ff.raster_height <= 16'd1;
         cfg_ff.tile_capacity <= 7'(CAP_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tlc_pkg::REG_TILE_WIDTH:    prdata = 32'(cfg_ff.tile_px_w);
         tlc_pkg::REG_TILE_HEIGHT:   prdata = 32'(cfg_ff.tile_px_h);
         tlc_pkg::REG_RASTER_WIDTH:  prdata = 32'(cfg_ff.raster_width);
         tlc_pkg::REG_RASTER_HEIGHT: prdata = 32'(cfg_ff.raster_height);
         tlc_pkg::REG_TILE_CAPACITY: prdata = 32'(cfg_ff.tile_capacity);
         default:                    prdata = '0;
      endcase
   end

   tlc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .tile_col (req_tile_col),
      .tile_row (req_tile_row),
      .mid_push (mid_push),
      .mid_data (mid_wdata),
      .mid_full (mid_full)
   );

   tlc_fifo #(
      .data_type (tlc_pkg::mid_item_type),
      .DEPTH     (2)
   ) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   tlc_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cfg_clear (cfg_clear),
      .mid_empty (mid_empty),
      .mid_data  (mid_rdata),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_wdata)
   );

   tlc_fifo #(
      .data_type (tlc_pkg::rsp_item_type),
      .DEPTH     (2)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_rdata),
      .empty     (empty)
   );

   assign rsp_hit           = out_rdata.hit;
   assign rsp_slot          = out_rdata.slot;
   assign rsp_bad_tile      = out_rdata.bad_tile;
   assign rsp_fetch_start_x = out_rdata.fetch_start_x;
   assign rsp_fetch_start_y = out_rdata.fetch_start_y;
   assign rsp_fetch_count_x = out_rdata.fetch_count_x;
   assign rsp_fetch_count_y = out_rdata.fetch_count_y;
   assign rsp_loaded_total  = out_rdata.loaded_total;

endmodule
